// File: design/mck_pkg.sv
// Shared types and constants for the Morse character keyer.
// Holds the Morse code tables and the code and element records; no dependencies.
`default_nettype none
package mck_pkg;

  // ASCII codes that bound the letter and digit ranges.
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  // Adding this folds a lower-case letter onto its upper-case code.
  localparam logic [7:0] CaseFold = ChUpperA - ChLowerA;

  localparam int unsigned MaxMarks = 5;

  // Element durations in dit units.
  localparam logic [2:0] DurDit       = 3'd1;
  localparam logic [2:0] DurDah       = 3'd3;
  localparam logic [2:0] DurMarkSpace = 3'd1;
  localparam logic [2:0] DurLetterGap = 3'd2;
  localparam logic [2:0] DurWordGap   = 3'd4;

  // Table entries are {mark count, dah bits}; bit i of the dah bits is set
  // when mark i (sent first at i = 0) is a dah.
  localparam logic [7:0] AlphaTab [26] = '{
    {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
    {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
    {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
    {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
    {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
    {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
    {3'd4, 5'b01101}, {3'd4, 5'b00011}
  };

  localparam logic [7:0] DigitTab [10] = '{
    {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
    {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
    {3'd5, 5'b00111}, {3'd5, 5'b01111}
  };

  // Decoded character: a separator sends only the word and letter gaps.
  typedef struct packed {
    logic       gap;
    logic [2:0] marks;
    logic [4:0] dah;
  } mck_code_t;

  // One keying element as it leaves the block.
  typedef struct packed {
    logic       key_on;
    logic [2:0] duration;
    logic       last;
  } mck_elem_t;

endpackage
`default_nettype wire

// File: design/mck_decode.sv
// Character decoder: folds case and looks up the Morse mark pattern.
// Depends on mck_pkg for the code tables and the code record.
`default_nettype none
module mck_decode (
  input  wire logic [7:0]        character,
  output mck_pkg::mck_code_t     code
);
  import mck_pkg::*;

  logic [7:0] upper;
  logic [7:0] alpha_ofs;
  logic [7:0] digit_ofs;
  logic [7:0] entry;

  always_comb begin
    if (character >= ChLowerA && character <= ChLowerZ) begin
      upper = character + CaseFold;
    end else begin
      upper = character;
    end
    alpha_ofs = upper - ChUpperA;
    digit_ofs = upper - ChDigit0;
    entry     = '0;
    code.gap  = 1'b0;
    if (upper >= ChUpperA && upper <= ChUpperZ) begin
      entry = AlphaTab[alpha_ofs[4:0]];
    end else if (upper >= ChDigit0 && upper <= ChDigit9) begin
      entry = DigitTab[digit_ofs[3:0]];
    end else begin
      code.gap = 1'b1;
    end
    code.marks = entry[7:5];
    code.dah   = entry[4:0];
  end

endmodule
`default_nettype wire

// File: design/mck_element.sv
// Element selector: gives the keying element at a given step of a character.
// Depends on mck_pkg for the code and element records and the durations.
`default_nettype none
module mck_element (
  input  wire mck_pkg::mck_code_t code,
  input  wire logic [3:0]         step,
  output mck_pkg::mck_elem_t      elem
);
  import mck_pkg::*;

  logic [3:0] gap_step;

  // Marks and spaces alternate; the letter gap follows the last mark space.
  assign gap_step = {code.marks, 1'b0};

  always_comb begin
    elem = '0;
    if (code.gap) begin
      elem.key_on   = 1'b0;
      elem.duration = (step == 4'd0) ? DurWordGap : DurLetterGap;
      elem.last     = (step != 4'd0);
    end else if (step >= gap_step) begin
      elem.key_on   = 1'b0;
      elem.duration = DurLetterGap;
      elem.last     = 1'b1;
    end else if (!step[0]) begin
      elem.key_on   = 1'b1;
      elem.duration = code.dah[step[3:1]] ? DurDah : DurDit;
      elem.last     = 1'b0;
    end else begin
      elem.key_on   = 1'b0;
      elem.duration = DurMarkSpace;
      elem.last     = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: design/morse_character_keyer.sv
// Morse character keyer, top level: input register, step counter, output register.
// The character is held in the current-character register and each element in the output register.
// Throughput: one element per cycle while the output is not stalled; a letter or
// digit of n marks gives 2n+1 elements (up to 11), any other character 2. The next
// character is taken as the current last element moves to the output register.
// Reset: synchronous, active low; clears the valid flags and the step counter.
`default_nettype none
module morse_character_keyer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_character,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_key_on,
  output logic [2:0]      out_duration_units,
  output logic            out_last_element
);
  import mck_pkg::*;

  mck_code_t  in_code;
  mck_code_t  cur_code_r;
  mck_code_t  cur_code_nxt;
  logic       cur_valid_r;
  logic       cur_valid_nxt;
  logic [3:0] step_r;
  logic [3:0] step_nxt;
  mck_elem_t  elem;
  mck_elem_t  out_elem_r;
  mck_elem_t  out_elem_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       load_out;
  logic       in_take;

  mck_decode u_decode (
    .character (in_character),
    .code      (in_code)
  );

  mck_element u_element (
    .code (cur_code_r),
    .step (step_r),
    .elem (elem)
  );

  assign load_out = cur_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !cur_valid_r || (load_out && elem.last);
  assign in_take  = in_valid && in_ready;

  always_comb begin
    cur_code_nxt  = cur_code_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (in_take) begin
      cur_code_nxt  = in_code;
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end else if (load_out) begin
      if (elem.last) begin
        cur_valid_nxt = 1'b0;
        step_nxt      = '0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
    out_elem_nxt  = load_out ? elem : out_elem_r;
    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_code_r <= cur_code_nxt;
    out_elem_r <= out_elem_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_key_on         = out_elem_r.key_on;
  assign out_duration_units = out_elem_r.duration;
  assign out_last_element   = out_elem_r.last;

endmodule
`default_nettype wire
